// ===== rtl/core/lflg_pkg.sv =====
// Package for the LCG-seeded lagged Fibonacci generator.
// Holds widths, lag limits, LCG constants and configuration register codes.
// No dependencies.
`timescale 1ns / 1ps

package lflg_pkg;

    localparam int MAX_LAG  = 1024;
    localparam int RING_AW  = $clog2(MAX_LAG);
    localparam int LAG_W    = 11;
    localparam int DATA_W   = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] LCG_MUL = 31'd1103515245;
    localparam logic [DATA_W-1:0] LCG_INC = 31'd12345;

    localparam logic [LAG_W-1:0]  LAG_LONG_RST  = 11'd55;
    localparam logic [LAG_W-1:0]  LAG_SHORT_RST = 11'd24;
    localparam logic [DATA_W-1:0] SEED_RST      = 31'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAG_LONG  = 2'd0,
        CFG_LAG_SHORT = 2'd1,
        CFG_SEED      = 2'd2
    } t_cfg_idx;

    // A lag of zero acts as one; a lag beyond the ring depth saturates.
    function automatic logic [LAG_W-1:0] eff_lag(input logic [LAG_W-1:0] v);
        logic [LAG_W-1:0] res;
        if (v == '0) begin
            res = LAG_W'(1);
        end else if (v > LAG_W'(MAX_LAG)) begin
            res = LAG_W'(MAX_LAG);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/lflg_req_if.sv =====
// Request channel of the lagged Fibonacci generator: valid, ready, restart flag.
// No dependencies.
`timescale 1ns / 1ps

interface lflg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// ===== rtl/core/lflg_rsp_if.sv =====
// Result channel of the lagged Fibonacci generator: valid, ready, sample, error.
// Depends on lflg_pkg.
`timescale 1ns / 1ps

interface lflg_rsp_if
    import lflg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sample;
    logic              config_error;

    modport source (output valid, output sample, output config_error, input ready);
    modport sink (input valid, input sample, input config_error, output ready);
endinterface

// ===== rtl/core/lflg_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Read data holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module lflg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== rtl/core/lcg_seeded_lagged_fibonacci_rng.sv =====
// Top level of the LCG-seeded additive lagged Fibonacci generator.
// Depends on lflg_pkg, lflg_req_if, lflg_rsp_if and lflg_ram.
`timescale 1ns / 1ps

// Each request transfer returns one 31-bit sample (an unsigned 0.31 fraction).
// The first lag_long samples after a restart are LCG states starting at
// seed_value; later samples are x[i-r] + x[i-s] mod 2^31, taken from a ring of
// MAX_LAG words in a RAM with two registered read ports. The block sustains one
// request per clock while the result side keeps up; each request passes through
// the read stage, where the RAM read completes, and then the output register,
// from which its result is offered. Reads that hit the entry being written in the
// same cycle are forwarded. Lag registers and the seed may be written only while
// no request is in flight; a short lag above the long lag yields config_error with
// a zero sample and no advance.
module lcg_seeded_lagged_fibonacci_rng
    import lflg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    lflg_req_if.sink             i_req,
    lflg_rsp_if.source           o_rsp
);

    // Configuration registers.
    logic [LAG_W-1:0]  r_lag_long;
    logic [LAG_W-1:0]  r_lag_short;
    logic [DATA_W-1:0] r_seed;

    // Sequence state.
    logic [RING_AW-1:0] r_pos;
    logic [LAG_W-1:0]   r_cnt;
    logic [DATA_W-1:0]  r_lcg;

    // Read stage.
    logic               r_s1_valid;
    logic               r_s1_err;
    logic               r_s1_seed;
    logic [DATA_W-1:0]  r_s1_x;
    logic [RING_AW-1:0] r_s1_pos;
    logic               r_s1_fwd_a;
    logic               r_s1_fwd_b;
    logic [DATA_W-1:0]  r_s1_fwd_data;

    // Output register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_sample;
    logic              r_out_err;

    logic               w_out_free;
    logic               w_s1_adv;
    logic               w_accept;
    logic               w_err;
    logic [LAG_W-1:0]   w_r;
    logic [LAG_W-1:0]   w_s;
    logic [RING_AW-1:0] w_pos_base;
    logic [LAG_W-1:0]   w_cnt_base;
    logic               w_seeding;
    logic [DATA_W-1:0]  w_x_seed;
    logic [DATA_W-1:0]  w_lcg_next;
    logic [LAG_W-1:0]   w_diff_a;
    logic [LAG_W-1:0]   w_diff_b;
    logic [RING_AW-1:0] w_raddr_a;
    logic [RING_AW-1:0] w_raddr_b;
    logic [DATA_W-1:0]  w_rdata_a;
    logic [DATA_W-1:0]  w_rdata_b;
    logic [DATA_W-1:0]  w_tap_a;
    logic [DATA_W-1:0]  w_tap_b;
    logic [DATA_W-1:0]  w_s1_x;
    logic               w_ram_we;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_s1_adv    = r_s1_valid && w_out_free;
    assign i_req.ready = !r_s1_valid || w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_err      = r_lag_short > r_lag_long;
    assign w_r        = eff_lag(r_lag_long);
    assign w_s        = eff_lag(r_lag_short);
    assign w_pos_base = i_req.restart ? '0 : r_pos;
    assign w_cnt_base = i_req.restart ? '0 : r_cnt;
    assign w_seeding  = w_cnt_base < w_r;
    assign w_x_seed   = (w_cnt_base == '0) ? r_seed : r_lcg;
    assign w_lcg_next = LCG_MUL * w_x_seed + LCG_INC;

    // Ring slots r and s back from the current position, modulo the depth.
    assign w_diff_a  = LAG_W'(w_pos_base) - w_r;
    assign w_diff_b  = LAG_W'(w_pos_base) - w_s;
    assign w_raddr_a = w_diff_a[RING_AW-1:0];
    assign w_raddr_b = w_diff_b[RING_AW-1:0];

    assign w_tap_a  = r_s1_fwd_a ? r_s1_fwd_data : w_rdata_a;
    assign w_tap_b  = r_s1_fwd_b ? r_s1_fwd_data : w_rdata_b;
    assign w_s1_x   = r_s1_seed ? r_s1_x : (w_tap_a + w_tap_b);
    assign w_ram_we = w_s1_adv && !r_s1_err;

    lflg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LAG)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_waddr   (r_s1_pos),
        .i_wdata   (w_s1_x),
        .i_re      (w_accept),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_long  <= LAG_LONG_RST;
            r_lag_short <= LAG_SHORT_RST;
            r_seed      <= SEED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LAG_LONG:  r_lag_long  <= i_cfg_data[LAG_W-1:0];
                CFG_LAG_SHORT: r_lag_short <= i_cfg_data[LAG_W-1:0];
                CFG_SEED:      r_seed      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_cnt      <= '0;
            r_lcg      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_err) begin
                    r_pos <= w_pos_base;
                    r_cnt <= w_cnt_base;
                end else begin
                    r_pos <= w_pos_base + 1'b1;
                    if (w_seeding) begin
                        r_cnt <= w_cnt_base + 1'b1;
                        r_lcg <= w_lcg_next;
                    end else begin
                        r_cnt <= w_cnt_base;
                    end
                end
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Payload of the read stage; the forward flags catch a read of the slot
    // that the completing item writes in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_err      <= w_err;
            r_s1_seed     <= w_seeding;
            r_s1_x        <= w_x_seed;
            r_s1_pos      <= w_pos_base;
            r_s1_fwd_a    <= w_ram_we && (r_s1_pos == w_raddr_a);
            r_s1_fwd_b    <= w_ram_we && (r_s1_pos == w_raddr_b);
            r_s1_fwd_data <= w_s1_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_sample <= r_s1_err ? '0 : w_s1_x;
            r_out_err    <= r_s1_err;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.sample       = r_out_sample;
    assign o_rsp.config_error = r_out_err;

    // An item in the read stage stays there until the output register frees.
    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> r_s1_valid)
        else $error("read stage item dropped while output stalled");

    // A good item advances the ring position by exactly one slot.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_err) |=> (r_pos == $past(w_pos_base) + 1'b1))
        else $error("ring position did not advance by one");

    // An error item leaves the LCG state untouched.
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_err) |=> $stable(r_lcg))
        else $error("LCG state changed on a configuration error");

    // An error result always carries a zero sample.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.config_error) |-> (o_rsp.sample == '0))
        else $error("configuration error with nonzero sample");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the LCG-seeded lagged Fibonacci generator.
// Drives the request channel and the register port, and predicts every sample.
// Depends on lflg_pkg, lflg_req_if, lflg_rsp_if and the top level.
`timescale 1ns / 1ps

module testbench;
    import lflg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              config_error;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0] i_cfg_data;

    lflg_req_if req_if ();
    lflg_rsp_if rsp_if ();

    lcg_seeded_lagged_fibonacci_rng u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Generator state as the testbench sees it.
    logic [LAG_W-1:0]   cfg_lag_long;
    logic [LAG_W-1:0]   cfg_lag_short;
    logic [DATA_W-1:0]  cfg_seed;
    logic [DATA_W-1:0]  hist_ring [MAX_LAG];
    logic [RING_AW-1:0] ring_wr_pos;
    logic [LAG_W-1:0]   seed_count;
    logic [DATA_W-1:0]  lcg_x;

    t_sample pending_samples [$];

    logic no_idle;
    int unsigned requests_sent;
    int unsigned restarts_sent;
    int unsigned error_samples;
    int unsigned settings_applied;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    function automatic logic [LAG_W-1:0] clamp_lag(input logic [LAG_W-1:0] v);
        logic [LAG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = LAG_W'(1);
        end else if (v > LAG_W'(MAX_LAG)) begin
            res = LAG_W'(MAX_LAG);
        end
        return res;
    endfunction

    task automatic predict_next(input logic restart, output t_sample res);
        logic [LAG_W-1:0]     r_lag;
        logic [LAG_W-1:0]     s_lag;
        logic [RING_AW-1:0]   r_idx;
        logic [RING_AW-1:0]   s_idx;
        logic [DATA_W-1:0]    x;
        logic [2*DATA_W:0]    prod;
        if (restart) begin
            seed_count  = '0;
            ring_wr_pos = '0;
        end
        // The raw register values decide the error; the sequence holds still.
        if (cfg_lag_short > cfg_lag_long) begin
            res.sample       = '0;
            res.config_error = 1'b1;
            error_samples++;
            return;
        end
        r_lag = clamp_lag(cfg_lag_long);
        s_lag = clamp_lag(cfg_lag_short);
        if (seed_count < r_lag) begin
            if (seed_count == '0) begin
                lcg_x = cfg_seed;
            end
            x     = lcg_x;
            prod  = (2*DATA_W+1)'(x) * (2*DATA_W+1)'(LCG_MUL) + (2*DATA_W+1)'(LCG_INC);
            lcg_x = prod[DATA_W-1:0];
            seed_count++;
        end else begin
            // A lag of MAX_LAG points at the slot about to be overwritten.
            r_idx = ring_wr_pos - r_lag[RING_AW-1:0];
            s_idx = ring_wr_pos - s_lag[RING_AW-1:0];
            x     = hist_ring[r_idx] + hist_ring[s_idx];
        end
        hist_ring[ring_wr_pos] = x;
        ring_wr_pos++;
        res.sample       = x;
        res.config_error = 1'b0;
    endtask

    // Entered just after a rising edge; returns at the edge of the transfer.
    task automatic send_request(input logic restart);
        t_sample expected_now;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 12) begin
            req_if.valid   <= 1'b0;
            req_if.restart <= 1'($urandom_range(0, 1));
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.restart <= restart;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predict_next(restart, expected_now);
        pending_samples.push_back(expected_now);
        requests_sent++;
        if (restart) begin
            restarts_sent++;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        // Every request returns a sample, so a short margin covers the pipeline.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [LAG_W-1:0] long_v, input logic [LAG_W-1:0] short_v,
                             input logic [DATA_W-1:0] seed_v);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LAG_LONG;
        i_cfg_data <= DATA_W'(long_v);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_LAG_SHORT;
        i_cfg_data <= DATA_W'(short_v);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SEED;
        i_cfg_data <= seed_v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_lag_long  = long_v;
        cfg_lag_short = short_v;
        cfg_seed      = seed_v;
        settings_applied++;
    endtask

    // Reset values: seeding starts from seed 1 without a restart.
    task automatic test_reset_values();
        repeat (3) send_request(1'b0);
    endtask

    // Both lags zero act as one, so after the seed each sample doubles the one before.
    task automatic test_zero_lags();
        configure('0, '0, '1);
        send_request(1'b1);
        repeat (4) send_request(1'b0);
    endtask

    task automatic test_short_above_long();
        configure(LAG_W'(2), LAG_W'(3), DATA_W'($urandom));
        send_request(1'b0);
        send_request(1'b1);
        configure(LAG_W'(3), LAG_W'(3), DATA_W'($urandom));
        repeat (3) send_request(1'b0);
    endtask

    task automatic test_saturated_lags();
        configure('1, '1, '0);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
    endtask

    // Raising the long lag after seeding makes seeding resume from the LCG state.
    task automatic test_long_lag_raised();
        configure(LAG_W'(2), LAG_W'(1), DATA_W'($urandom));
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        configure(LAG_W'(4), LAG_W'(2), DATA_W'($urandom));
        repeat (4) send_request(1'b0);
    endtask

    task automatic test_random_settings();
        int unsigned sent_here;
        int unsigned phase;
        int unsigned n_items;
        logic [LAG_W-1:0]  long_v;
        logic [LAG_W-1:0]  short_v;
        logic [DATA_W-1:0] seed_v;
        logic keep_going;
        sent_here = 0;
        phase     = 0;
        while (sent_here < 360) begin
            case ($urandom_range(0, 9))
                0: long_v = '0;
                1: long_v = LAG_W'($urandom_range(1025, 2047));
                2: long_v = LAG_W'($urandom_range(41, 1024));
                default: long_v = LAG_W'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 9))
                0: short_v = (long_v == '1) ? long_v
                                            : LAG_W'($urandom_range(long_v + 1, 2047));
                1: short_v = '0;
                default: short_v = LAG_W'($urandom_range(0, long_v));
            endcase
            case ($urandom_range(0, 7))
                0: seed_v = '0;
                1: seed_v = '1;
                default: seed_v = DATA_W'($urandom);
            endcase
            configure(long_v, short_v, seed_v);
            if (long_v <= LAG_W'(40)) begin
                n_items = 2 * clamp_lag(long_v) + $urandom_range(1, 40);
            end else begin
                n_items = $urandom_range(5, 30);
            end
            // Now and then the old sequence carries on under the new lags.
            keep_going = ($urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < n_items; i++) begin
                if (phase == 3 && i == n_items / 2) begin
                    drain_results();
                end
                send_request((i == 0 && !keep_going) || $urandom_range(0, 49) == 0);
            end
            phase++;
            sent_here += n_items;
        end
    endtask

    // One run long enough to read back at the full ring depth and wrap the ring.
    task automatic test_max_lag_run();
        configure('1, LAG_W'($urandom_range(1, 2047)), DATA_W'($urandom));
        no_idle = 1'b1;
        send_request(1'b1);
        for (int unsigned i = 0; i < 1099; i++) begin
            if (i == 400) begin
                no_idle = 1'b0;
            end
            send_request(1'b0);
        end
    endtask

    always @(negedge i_clk) begin
        rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 12);
    end

    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected result transfer: sample %0d, config_error %0b",
                       rsp_if.sample, rsp_if.config_error);
                mismatch_count++;
            end else begin
                want = pending_samples.pop_front();
                if (rsp_if.sample !== want.sample) begin
                    $error("sample mismatch: expected %0d, actual %0d",
                           want.sample, rsp_if.sample);
                    mismatch_count++;
                end
                if (rsp_if.config_error !== want.config_error) begin
                    $error("config_error mismatch: expected %0b, actual %0b",
                           want.config_error, rsp_if.config_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        req_if.valid     = 1'b0;
        req_if.restart   = 1'b0;
        rsp_if.ready     = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_LAG_LONG;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        no_idle          = 1'b0;
        requests_sent    = 0;
        restarts_sent    = 0;
        error_samples    = 0;
        settings_applied = 0;
        mismatch_count   = 0;
        cfg_lag_long     = LAG_LONG_RST;
        cfg_lag_short    = LAG_SHORT_RST;
        cfg_seed         = SEED_RST;
        ring_wr_pos      = '0;
        seed_count       = '0;
        lcg_x            = '0;
        foreach (hist_ring[i]) begin
            hist_ring[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_zero_lags();
        test_short_above_long();
        test_saturated_lags();
        test_long_lag_raised();
        test_random_settings();
        test_max_lag_run();

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests (%0d with restart, %0d lag errors) over %0d settings",
                 requests_sent, restarts_sent, error_samples, settings_applied);
        $display("of lags and seed, in %0d cycles, with %0d mismatches",
                 cycle_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
